[sv/i2cm_pkg.sv]
// Shared types and constants for the I2C register-access master.
// No dependencies.
package i2cm_pkg;
  localparam int CountWidthDef = 16;
  localparam int TimerWidthDef = 16;
  localparam logic [7:0] MSB_BIT = 8'h80;

  typedef enum logic [3:0] {
    P_IDLE, P_START_0, P_START_A, P_START_B, P_TX_LOW, P_TX_HIGH, P_ACK_LOW,
    P_ACK_HIGH, P_POLL, P_RX_LOW, P_RX_HIGH, P_MACK_LOW, P_MACK_HIGH,
    P_STOP_A, P_STOP_B, P_STOP_C
  } phase_t;

  typedef enum logic [1:0] {ST_DEV_W, ST_REG, ST_DEV_R, ST_DATA} stage_t;
  typedef enum logic [1:0] {K_BWR, K_BRD, K_FWR, K_FRD} kind_t;
  typedef enum logic [1:0] {S_OK, S_NACK, S_BADFIELD} status_t;

  localparam logic [1:0] CFG_HALF = 2'd0;
  localparam logic [1:0] CFG_LIMIT = 2'd1;
  localparam logic [1:0] CFG_POLL = 2'd2;

  // input item packed: cmd_start,kind,dev,reg,count,wr,bstart,blen,sda = 50 bits
  typedef struct packed {
    logic       sda;
    logic [3:0] blen;
    logic [2:0] bstart;
    logic [7:0] wr;
    logic [15:0] cnt;
    logic [7:0] rega;
    logic [6:0] dev;
    logic [1:0] kind;
    logic       start;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       done;
    logic [7:0] rd;
    logic       valid;
    logic       taken;
    logic       busy;
    logic       sda;
    logic       scl;
  } res_t;
endpackage

[sv/i2cm_front.sv]
// Front part: accepts input words and queues them (two-entry queue).
// Depends on i2cm_pkg.
module i2cm_front import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [47:0] in_data,
  input  logic [1:0]  in_user,
  output logic        q_valid,
  input  logic        q_ready,
  output item_t       q_item
);
  item_t  mem_r [2];
  logic   wp_r, rp_r;
  logic [1:0] cnt_r;
  logic   push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    // kind rides on tuser; put it back between cmd_start and dev_addr
    if (push) mem_r[wp_r] <= item_t'({in_data[47:1], in_user, in_data[0]});
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[sv/i2cm_back.sv]
// Back part: bus sequencer, one queued word per tick, registered result.
// Depends on i2cm_pkg.
module i2cm_back import i2cm_pkg::*; #(
  parameter int COUNT_WIDTH = CountWidthDef,
  parameter int TIMER_WIDTH = TimerWidthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  input  logic [15:0] half_ticks,
  input  logic [7:0]  poll_limit,
  input  logic [15:0] poll_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_res
);
  phase_t phase_r, phase_nxt;
  stage_t stage_r, stage_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [COUNT_WIDTH-1:0] left_r, left_nxt;
  logic [7:0] sh_r, sh_nxt;
  logic [TIMER_WIDTH-1:0] tick_r, tick_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic [6:0] dev_r, dev_nxt;
  logic [7:0] reg_r, reg_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] mask_r, mask_nxt, fval_r, fval_nxt;
  logic [2:0] fsh_r, fsh_nxt;
  logic second_r, second_nxt, fail_r, fail_nxt;
  logic [1:0] stat_r, stat_nxt;
  logic taken, valid, done;
  logic [7:0] rd;
  logic scl, sda;
  logic step;
  logic [16:0] lim17;
  logic [TIMER_WIDTH-1:0] lim;
  logic [15:0] raw;
  logic [3:0] bnext;
  logic [7:0] bshift;
  logic writing;

  assign step = q_valid && q_ready;
  assign q_ready = !out_valid || out_ready;

  always_comb begin
    raw = (phase_r == P_POLL) ? poll_ticks : half_ticks;
    lim17 = (raw == 16'd0) ? 17'd0 : {1'b0, raw} - 17'd1;
    if (TIMER_WIDTH < 17 && (lim17 >> TIMER_WIDTH) != 17'd0) lim = '1;
    else lim = TIMER_WIDTH'(lim17);
  end

  always_comb begin
    phase_nxt = phase_r; stage_nxt = stage_r; bit_nxt = bit_r; left_nxt = left_r;
    sh_nxt = sh_r; tick_nxt = tick_r; poll_nxt = poll_r; dev_nxt = dev_r;
    reg_nxt = reg_r; kind_nxt = kind_r; mask_nxt = mask_r; fval_nxt = fval_r;
    fsh_nxt = fsh_r; second_nxt = second_r; fail_nxt = fail_r; stat_nxt = stat_r;
    taken = 1'b0; valid = 1'b0; done = 1'b0; rd = 8'd0;
    bnext = bit_r + 4'd1;
    bshift = {sh_r[6:0], q_item.sda};
    writing = (kind_r == K_BWR) || (kind_r == K_FWR && second_r);
    if (phase_r == P_IDLE) begin
      if (q_item.start) begin
        kind_nxt = q_item.kind; dev_nxt = q_item.dev; reg_nxt = q_item.rega;
        second_nxt = 1'b0; fail_nxt = 1'b0; poll_nxt = 8'd0;
        if (q_item.kind[1]) begin
          if (q_item.blen == 4'd0 || q_item.blen > 4'd8 ||
              q_item.blen > {1'b0, q_item.bstart} + 4'd1) begin
            stat_nxt = S_BADFIELD; done = 1'b1;
          end else begin
            fsh_nxt = 3'(({1'b0, q_item.bstart} + 4'd1) - q_item.blen);
            mask_nxt = 8'(((9'd1 << q_item.blen) - 9'd1) << fsh_nxt);
            fval_nxt = q_item.wr;
            left_nxt = COUNT_WIDTH'(1);
          end
        end else begin
          left_nxt = COUNT_WIDTH'(q_item.cnt);
        end
        if (!done) begin
          sh_nxt = {q_item.dev, 1'b0}; bit_nxt = 4'd0; stage_nxt = ST_DEV_W;
          phase_nxt = P_START_A; tick_nxt = '0;
        end
      end
    end else if (tick_r < lim) begin
      tick_nxt = tick_r + 1'b1;
    end else begin
      tick_nxt = '0;
      case (phase_r)
        P_START_0: phase_nxt = P_START_A;
        P_START_A: phase_nxt = P_START_B;
        P_START_B: begin bit_nxt = 4'd0; phase_nxt = P_TX_LOW; end
        P_TX_LOW: phase_nxt = P_TX_HIGH;
        P_TX_HIGH: begin
          sh_nxt = {sh_r[6:0], 1'b0}; bit_nxt = bnext;
          phase_nxt = (bnext >= 4'd8) ? P_ACK_LOW : P_TX_LOW;
        end
        P_ACK_LOW: phase_nxt = P_ACK_HIGH;
        P_RX_LOW: phase_nxt = P_RX_HIGH;
        P_RX_HIGH: begin
          sh_nxt = bshift; bit_nxt = bnext;
          if (bnext >= 4'd8) begin
            left_nxt = left_r - 1'b1;
            if (kind_r == K_BRD) begin valid = 1'b1; rd = bshift; end
            else if (kind_r == K_FRD) begin valid = 1'b1; rd = (bshift & mask_r) >> fsh_r; end
            else if (kind_r == K_FWR)
              fval_nxt = (bshift & ~mask_r) | ((fval_r << fsh_r) & mask_r);
            phase_nxt = P_MACK_LOW;
          end else phase_nxt = P_RX_LOW;
        end
        P_MACK_LOW: phase_nxt = P_MACK_HIGH;
        P_MACK_HIGH:
          if (left_r != '0) begin bit_nxt = 4'd0; sh_nxt = 8'd0; phase_nxt = P_RX_LOW; end
          else phase_nxt = P_STOP_A;
        P_STOP_A: phase_nxt = P_STOP_B;
        P_STOP_B: phase_nxt = P_STOP_C;
        P_STOP_C:
          if (!fail_r && kind_r == K_FWR && !second_r) begin
            second_nxt = 1'b1; left_nxt = COUNT_WIDTH'(1); sh_nxt = {dev_r, 1'b0};
            bit_nxt = 4'd0; stage_nxt = ST_DEV_W; phase_nxt = P_START_A;
          end else begin
            stat_nxt = fail_r ? S_NACK : S_OK; done = 1'b1; phase_nxt = P_IDLE;
          end
        default: begin // ACK_HIGH and POLL
          if (phase_r == P_POLL && poll_r >= poll_limit) begin
            fail_nxt = 1'b1; phase_nxt = P_STOP_A;
          end else if (phase_r == P_ACK_HIGH && q_item.sda) begin
            poll_nxt = 8'd0; phase_nxt = P_POLL;
          end else if (phase_r == P_POLL && q_item.sda) begin
            poll_nxt = poll_r + 8'd1;
          end else begin
            // acknowledged: advance to the next byte
            poll_nxt = 8'd0;
            case (stage_r)
              ST_DEV_W: begin
                sh_nxt = reg_r; bit_nxt = 4'd0; stage_nxt = ST_REG; phase_nxt = P_TX_LOW;
              end
              ST_REG:
                if (writing) begin
                  if (left_r != '0) begin
                    bit_nxt = 4'd0; stage_nxt = ST_DATA; phase_nxt = P_TX_LOW;
                    if (second_r) sh_nxt = fval_r;
                    else begin sh_nxt = q_item.wr; taken = 1'b1; end
                  end else phase_nxt = P_STOP_A;
                end else begin
                  sh_nxt = {dev_r, 1'b1}; bit_nxt = 4'd0; stage_nxt = ST_DEV_R;
                  phase_nxt = P_START_0;
                end
              ST_DEV_R:
                if (left_r != '0) begin
                  bit_nxt = 4'd0; sh_nxt = 8'd0; phase_nxt = P_RX_LOW;
                end else phase_nxt = P_STOP_A;
              default: begin
                left_nxt = left_r - 1'b1;
                if (left_nxt != '0) begin
                  bit_nxt = 4'd0; stage_nxt = ST_DATA; phase_nxt = P_TX_LOW;
                  if (second_r) sh_nxt = fval_r;
                  else begin sh_nxt = q_item.wr; taken = 1'b1; end
                end else phase_nxt = P_STOP_A;
              end
            endcase
          end
        end
      endcase
    end
    scl = 1'b1; sda = 1'b1;
    case (phase_nxt)
      P_START_0: scl = 1'b0;
      P_START_B: sda = 1'b0;
      P_TX_LOW: begin scl = 1'b0; sda = |(sh_nxt & MSB_BIT); end
      P_TX_HIGH: sda = |(sh_nxt & MSB_BIT);
      P_ACK_LOW, P_RX_LOW: scl = 1'b0;
      P_MACK_LOW: begin scl = 1'b0; sda = (left_nxt == '0); end
      P_MACK_HIGH: sda = (left_nxt == '0);
      P_STOP_A: begin scl = 1'b0; sda = 1'b0; end
      P_STOP_B: sda = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (step)
      out_res <= '{status: stat_nxt, done: done, rd: rd, valid: valid, taken: taken,
                   busy: (phase_nxt != P_IDLE), sda: sda, scl: scl};
    if (!rst_n) begin
      phase_r <= P_IDLE; stage_r <= ST_DEV_W; bit_r <= '0; left_r <= '0; sh_r <= '0;
      tick_r <= '0; poll_r <= '0; dev_r <= '0; reg_r <= '0; kind_r <= '0;
      mask_r <= '0; fval_r <= '0; fsh_r <= '0; second_r <= 1'b0; fail_r <= 1'b0;
      stat_r <= S_OK; out_valid <= 1'b0;
    end else begin
      if (step) begin
        phase_r <= phase_nxt; stage_r <= stage_nxt; bit_r <= bit_nxt;
        left_r <= left_nxt; sh_r <= sh_nxt; tick_r <= tick_nxt; poll_r <= poll_nxt;
        dev_r <= dev_nxt; reg_r <= reg_nxt; kind_r <= kind_nxt; mask_r <= mask_nxt;
        fval_r <= fval_nxt; fsh_r <= fsh_nxt; second_r <= second_nxt;
        fail_r <= fail_nxt; stat_r <= stat_nxt;
        out_valid <= 1'b1;
      end else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule

[sv/i2c_master_register_access.sv]
// I2C register-access master.
// Each input word is one clock tick of the bus engine and carries the
// command fields plus the sampled SDA level; each tick yields exactly one
// result word with SCL/SDA drive, busy, byte_taken, read data, done and
// status. Commands: burst write, burst read, field write, field read.
// Input words pass through a two-entry queue into the bus sequencer,
// whose result goes into an output register.
// Throughput: one word per cycle while the receiver does not stall. With the
// queue empty, an accepted word is registered in the queue, then its result is
// registered in the result register that drives out_tvalid.
// When the receiver stalls, the result register holds, then the queue fills
// and in_tready drops; no word is lost.
// Reset (rst_n low, synchronous) empties queue and result, sets the sequencer
// idle, status 0, and restores register defaults 50 / 100 / 200.
// Config (cfg_valid/cfg_ready, always ready): index 0 half_bit_ticks,
// 1 ack_poll_limit, 2 ack_poll_ticks; other indexes are ignored.
// Depends on i2cm_pkg, i2cm_front, i2cm_back.
module i2c_master_register_access import i2cm_pkg::*; #(
  parameter int COUNT_WIDTH = CountWidthDef,
  parameter int TIMER_WIDTH = TimerWidthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // start, dev_addr[7], reg_addr[8], byte_count[16], wr_byte[8],
  // bit_start[3], bit_length[4], sda_in
  input  logic [47:0] in_tdata,
  // kind[2]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // scl_out, sda_out, busy_res, byte_taken, rd_valid, rd_byte[8], done_res,
  // status[2]
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic [15:0] half_r, pticks_r;
  logic [7:0]  limit_r;
  logic  q_valid, q_ready;
  item_t q_item;
  res_t  res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 16'd50; limit_r <= 8'd100; pticks_r <= 16'd200;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HALF: half_r <= cfg_data;
        CFG_LIMIT: limit_r <= cfg_data[7:0];
        CFG_POLL: pticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  i2cm_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_data(in_tdata),
    .in_user(in_tuser), .q_valid, .q_ready, .q_item
  );

  i2cm_back #(.COUNT_WIDTH(COUNT_WIDTH), .TIMER_WIDTH(TIMER_WIDTH)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item, .half_ticks(half_r),
    .poll_limit(limit_r), .poll_ticks(pticks_r), .out_valid(out_tvalid),
    .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = res;
endmodule

[sv/i2cm_checker.sv]
// Port-level checks for the I2C register-access master, bound to the top.
// Depends on i2c_master_register_access ports only.
module i2cm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed under stall");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13] |-> !out_tdata[2])
    else $error("done while busy");
  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[4] |-> out_tdata[12:5] == 8'd0)
    else $error("read data without valid");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:14] != 2'b11)
    else $error("bad status code");
endmodule

bind i2c_master_register_access i2cm_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);

[test/i2c_master_register_access_tb.sv]
// Self-checking bench for the I2C register-access master: drives tick words with
// commands and sampled SDA, predicts every result word and compares field by field.
// Depends on i2cm_pkg and the i2c_master_register_access RTL.
module i2c_master_register_access_tb;
  import i2cm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_OFF_CYCLES = 300;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  i2c_master_register_access DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  item_t       tick_q[$];
  res_t        bus_expect_q[$];
  int          errors = 0;
  int          words_checked = 0;
  int          cmds_done = 0;
  int          nack_ends = 0;
  int          bad_field_ends = 0;
  int          read_words = 0;
  int          cyc = 0;
  bit          hold_off_req = 0;
  int          hold_left = 0;

  // Predictor state
  logic [15:0] half_ticks, poll_limit_q, poll_ticks;
  phase_t      ph;
  stage_t      stg;
  kind_t       kind_s;
  logic [3:0]  bitn;
  logic [15:0] left_n;
  logic [7:0]  sh;
  logic [15:0] tick;
  logic [7:0]  polls;
  logic [6:0]  dev_s;
  logic [7:0]  reg_s;
  logic [7:0]  fmask;
  logic [2:0]  fshift;
  logic [7:0]  fval;
  logic [1:0]  status_r;
  bit          second_pass, failed;
  bit          o_taken, o_valid, o_done;
  logic [7:0]  o_rd;

  initial clk = 0;
  always #5 clk = ~clk;

  always @(posedge clk) cyc <= cyc + 1;

  function automatic bit quiet_window();
    return cyc >= 2000 && cyc < 3000;
  endfunction

  function automatic void go_to(phase_t p);
    ph = p;
    tick = '0;
  endfunction

  function automatic void send_byte(logic [7:0] b, stage_t s);
    sh = b;
    bitn = '0;
    stg = s;
    go_to(P_TX_LOW);
  endfunction

  function automatic void next_write(logic [7:0] wr);
    if (left_n != 0) begin
      send_byte(second_pass ? fval : 8'd0, ST_DATA);
      if (!second_pass) begin
        sh = wr;
        o_taken = 1;
      end
    end else begin
      go_to(P_STOP_A);
    end
  endfunction

  function automatic void acked(logic [7:0] wr);
    polls = '0;
    case (stg)
      ST_DEV_W: send_byte(reg_s, ST_REG);
      ST_REG: begin
        if (kind_s == K_BWR || (kind_s == K_FWR && second_pass)) begin
          next_write(wr);
        end else begin
          sh = {dev_s, 1'b1};
          bitn = '0;
          stg = ST_DEV_R;
          go_to(P_START_0);
        end
      end
      ST_DEV_R: begin
        if (left_n != 0) begin
          bitn = '0;
          sh = '0;
          go_to(P_RX_LOW);
        end else begin
          go_to(P_STOP_A);
        end
      end
      default: begin
        left_n = left_n - 1;
        next_write(wr);
      end
    endcase
  endfunction

  function automatic void got_byte();
    left_n = left_n - 1;
    if (kind_s == K_BRD) begin
      o_valid = 1;
      o_rd = sh;
    end else if (kind_s == K_FRD) begin
      o_valid = 1;
      o_rd = (sh & fmask) >> fshift;
    end else if (kind_s == K_FWR) begin
      fval = (sh & ~fmask) | ((fval << fshift) & fmask);
    end
    go_to(P_MACK_LOW);
  endfunction

  function automatic void end_of_phase(logic sda, logic [7:0] wr);
    case (ph)
      P_START_0: go_to(P_START_A);
      P_START_A: go_to(P_START_B);
      P_START_B: begin
        bitn = '0;
        go_to(P_TX_LOW);
      end
      P_TX_LOW: go_to(P_TX_HIGH);
      P_TX_HIGH: begin
        sh = sh << 1;
        bitn = bitn + 1;
        go_to(bitn >= 8 ? P_ACK_LOW : P_TX_LOW);
      end
      P_ACK_LOW: go_to(P_ACK_HIGH);
      P_ACK_HIGH: begin
        if (!sda) acked(wr);
        else begin
          polls = '0;
          go_to(P_POLL);
        end
      end
      P_POLL: begin
        if (polls >= poll_limit_q[7:0]) begin
          failed = 1;
          go_to(P_STOP_A);
        end else begin
          polls = polls + 1;
          if (!sda) acked(wr);
          else go_to(P_POLL);
        end
      end
      P_RX_LOW: go_to(P_RX_HIGH);
      P_RX_HIGH: begin
        sh = {sh[6:0], sda};
        bitn = bitn + 1;
        if (bitn >= 8) got_byte();
        else go_to(P_RX_LOW);
      end
      P_MACK_LOW: go_to(P_MACK_HIGH);
      P_MACK_HIGH: begin
        if (left_n != 0) begin
          bitn = '0;
          sh = '0;
          go_to(P_RX_LOW);
        end else begin
          go_to(P_STOP_A);
        end
      end
      P_STOP_A: go_to(P_STOP_B);
      P_STOP_B: go_to(P_STOP_C);
      default: begin
        // a field write reads first, then goes around again to write back
        if (!failed && kind_s == K_FWR && !second_pass) begin
          second_pass = 1;
          left_n = 1;
          sh = {dev_s, 1'b0};
          bitn = '0;
          stg = ST_DEV_W;
          go_to(P_START_A);
        end else begin
          status_r = failed ? S_NACK : S_OK;
          o_done = 1;
          go_to(P_IDLE);
        end
      end
    endcase
  endfunction

  function automatic res_t bus_tick(item_t it);
    res_t r;
    int   lim;
    o_taken = 0;
    o_valid = 0;
    o_done = 0;
    o_rd = '0;
    if (ph == P_IDLE) begin
      if (it.start) begin
        kind_s = kind_t'(it.kind);
        dev_s = it.dev;
        reg_s = it.rega;
        second_pass = 0;
        failed = 0;
        polls = '0;
        if (it.kind >= 2) begin
          if (it.blen == 0 || it.blen > 8 || int'(it.blen) > int'(it.bstart) + 1) begin
            status_r = S_BADFIELD;
            o_done = 1;
          end else begin
            fshift = 3'(int'(it.bstart) + 1 - int'(it.blen));
            fmask = 8'(((1 << it.blen) - 1) << fshift);
            fval = it.wr;
            left_n = 1;
          end
        end else begin
          left_n = it.cnt;
        end
        if (!o_done) begin
          sh = {it.dev, 1'b0};
          bitn = '0;
          stg = ST_DEV_W;
          go_to(P_START_A);
        end
      end
    end else begin
      lim = (ph == P_POLL) ? poll_ticks : half_ticks;
      lim = (lim == 0) ? 0 : lim - 1;
      if (int'(tick) >= lim) end_of_phase(it.sda, it.wr);
      else tick = tick + 1;
    end
    r = '0;
    r.scl = 1;
    r.sda = 1;
    case (ph)
      P_START_0: r.scl = 0;
      P_START_B: r.sda = 0;
      P_TX_LOW: begin
        r.scl = 0;
        r.sda = sh[7];
      end
      P_TX_HIGH: r.sda = sh[7];
      P_ACK_LOW, P_RX_LOW: r.scl = 0;
      P_MACK_LOW: begin
        r.scl = 0;
        r.sda = (left_n == 0);
      end
      P_MACK_HIGH: r.sda = (left_n == 0);
      P_STOP_A: begin
        r.scl = 0;
        r.sda = 0;
      end
      P_STOP_B: r.sda = 0;
      default: ;
    endcase
    r.busy = (ph != P_IDLE);
    r.taken = o_taken;
    r.valid = o_valid;
    r.rd = o_valid ? o_rd : 8'd0;
    r.done = o_done;
    r.status = status_r;
    return r;
  endfunction

  function automatic item_t pack_tick(bit start, logic [1:0] kind, logic [6:0] dev,
      logic [7:0] rega, logic [15:0] cnt, logic [7:0] wr, logic [2:0] bstart,
      logic [3:0] blen, bit sda);
    item_t it;
    it.start = start;
    it.kind = kind;
    it.dev = dev;
    it.rega = rega;
    it.cnt = cnt;
    it.wr = wr;
    it.bstart = bstart;
    it.blen = blen;
    it.sda = sda;
    return it;
  endfunction

  // Driver: hold the word until accepted, idle at random outside the quiet window
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (tick_q.size() != 0 && (quiet_window() || $urandom_range(0, 99) >= 38)) begin
        {in_tdata[47:1], in_tuser, in_tdata[0]} <= tick_q.pop_front();
        in_tvalid <= 1;
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else if (hold_off_req && hold_left == 0) begin
      hold_off_req <= 0;
      hold_left <= HOLD_OFF_CYCLES;
      out_tready <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= (hold_left == 1);
    end else begin
      out_tready <= quiet_window() || $urandom_range(0, 99) >= 38;
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Predict on accept, check on result
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        bus_expect_q.push_back(bus_tick(item_t'({in_tdata[47:1], in_tuser, in_tdata[0]})));
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata);
        if (bus_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word %h", $time, out_tdata);
        end else begin
          want = bus_expect_q.pop_front();
          words_checked++;
          check_field("scl_out", want.scl, got.scl);
          check_field("sda_out", want.sda, got.sda);
          check_field("busy_res", want.busy, got.busy);
          check_field("byte_taken", want.taken, got.taken);
          check_field("rd_valid", want.valid, got.valid);
          check_field("rd_byte", want.rd, got.rd);
          check_field("done_res", want.done, got.done);
          check_field("status", want.status, got.status);
          if (want.valid) read_words++;
          if (want.done) begin
            cmds_done++;
            if (want.status == S_NACK) nack_ends++;
            if (want.status == S_BADFIELD) bad_field_ends++;
          end
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      CFG_HALF: half_ticks = val;
      CFG_LIMIT: poll_limit_q = {8'd0, val[7:0]};
      CFG_POLL: poll_ticks = val;
      default: ;
    endcase
  endtask

  task automatic set_timing(logic [15:0] half, logic [7:0] limit, logic [15:0] poll);
    write_reg(CFG_HALF, half);
    write_reg(CFG_LIMIT, {8'd0, limit});
    write_reg(CFG_POLL, poll);
  endtask

  // mode 0: SDA always acknowledges, 1: mostly low, 2: always high
  task automatic push_idle(int mode);
    bit sda;
    sda = (mode == 0) ? 0 : (mode == 2) ? 1 : ($urandom_range(0, 9) < 3);
    tick_q.push_back(pack_tick(0, 2'($urandom), 7'($urandom), 8'($urandom), 16'($urandom),
                               8'($urandom), 3'($urandom), 4'($urandom), sda));
  endtask

  task automatic drain();
    do @(posedge clk);
    while (tick_q.size() != 0 || in_tvalid || bus_expect_q.size() != 0);
  endtask

  // Run the bus with filler ticks until the command is over
  task automatic settle(int mode);
    int n;
    n = 0;
    drain();
    while (ph != P_IDLE) begin
      repeat (32) push_idle(n < 200 ? mode : 2);
      n++;
      drain();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic cmd(kind_t kind, logic [6:0] dev, logic [7:0] rega, logic [15:0] cnt,
      logic [7:0] wr, logic [2:0] bstart, logic [3:0] blen, int mode);
    tick_q.push_back(pack_tick(1, kind, dev, rega, cnt, wr, bstart, blen, 0));
    settle(mode);
  endtask

  task automatic random_run(int ticks);
    bit          st;
    logic [2:0]  bs;
    logic [3:0]  bl;
    for (int i = 0; i < ticks; i++) begin
      st = ($urandom_range(0, 19) == 0);
      bs = 3'($urandom);
      bl = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(1, bs + 1));
      tick_q.push_back(pack_tick(st, 2'($urandom), 7'($urandom), 8'($urandom),
                                 st ? 16'($urandom_range(0, 3)) : 16'($urandom),
                                 8'($urandom), bs, bl, $urandom_range(0, 9) < 3));
    end
    settle(1);
  endtask

  initial begin
    rst_n = 0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    half_ticks = 50;
    poll_limit_q = 100;
    poll_ticks = 200;
    ph = P_IDLE;
    stg = ST_DEV_W;
    kind_s = K_BWR;
    {bitn, left_n, sh, tick, polls, dev_s, reg_s, fmask, fshift, fval, status_r} = '0;
    second_pass = 0;
    failed = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    set_timing(2, 100, 200);
    cmd(K_BWR, 7'h7F, 8'hFF, 16'd1, 8'hA5, 3'd0, 4'd0, 0);

    set_timing(1, 0, 1);
    cmd(K_FRD, 7'h12, 8'h34, 16'd0, 8'h00, 3'd3, 4'd0, 0);     // zero width
    cmd(K_FWR, 7'h12, 8'h34, 16'd0, 8'hFF, 3'd7, 4'd9, 0);     // wider than a byte
    cmd(K_FWR, 7'h12, 8'h34, 16'd0, 8'hFF, 3'd7, 4'd15, 0);
    cmd(K_FRD, 7'h12, 8'h34, 16'd0, 8'h00, 3'd2, 4'd4, 0);     // field runs below bit 0
    cmd(K_BWR, 7'h00, 8'h00, 16'd0, 8'h00, 3'd0, 4'd0, 0);     // empty bursts
    cmd(K_BRD, 7'h55, 8'hAA, 16'd0, 8'h00, 3'd0, 4'd0, 0);
    cmd(K_BRD, 7'h2A, 8'h0F, 16'd2, 8'h00, 3'd0, 4'd0, 1);
    cmd(K_BWR, 7'h01, 8'h80, 16'd3, 8'h5A, 3'd0, 4'd0, 1);
    cmd(K_FRD, 7'h7F, 8'hFF, 16'd0, 8'h00, 3'd7, 4'd8, 1);
    cmd(K_FRD, 7'h40, 8'h01, 16'd0, 8'h00, 3'd0, 4'd1, 1);
    cmd(K_FWR, 7'h33, 8'h44, 16'd0, 8'hFF, 3'd5, 4'd3, 1);
    cmd(K_FWR, 7'h33, 8'h44, 16'd0, 8'h00, 3'd7, 4'd8, 0);
    cmd(K_BWR, 7'h7F, 8'hFF, 16'hFFFF, 8'hFF, 3'd7, 4'hF, 2); // target never answers
    cmd(K_FWR, 7'h20, 8'h02, 16'd0, 8'h01, 3'd4, 4'd2, 2);
    // a second start while busy must be ignored
    tick_q.push_back(pack_tick(1, K_BWR, 7'h10, 8'h20, 16'd1, 8'h33, 3'd0, 4'd0, 0));
    tick_q.push_back(pack_tick(1, K_BRD, 7'h11, 8'h21, 16'd9, 8'h00, 3'd0, 4'd0, 0));
    settle(0);

    set_timing(16'hFFFF, 8'hFF, 16'hFFFF);
    cmd(K_FRD, 7'h0F, 8'hF0, 16'd0, 8'h00, 3'd1, 4'd5, 0);
    repeat (8) push_idle(1);
    settle(2);

    set_timing(1, 2, 1);
    hold_off_req = 1;
    random_run(100);
    set_timing(2, 5, 3);
    random_run(100);
    set_timing(1, 255, 1);
    random_run(100);
    set_timing(3, 1, 2);
    random_run(40);

    $display("Checked %0d result words, %0d read words; %0d commands ended",
             words_checked, read_words, cmds_done);
    $display("  (%0d on missing acknowledge, %0d on invalid field)", nack_ends, bad_field_ends);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout at %0t", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

[i2c_master_register_access.f]
sv/i2cm_pkg.sv
sv/i2cm_front.sv
sv/i2cm_back.sv
sv/i2c_master_register_access.sv
sv/i2cm_checker.sv
test/i2c_master_register_access_tb.sv
